// ===== rtl/core/pflg_pkg.sv =====
// ----------------------------------------------------------------------------
// pflg_pkg: shared types, codes and tables of the frame loss core
// Holds the loss mode and register codes, the word layouts passed between
// the front, the queue and the back, and the interpolation tables.
// ----------------------------------------------------------------------------
package pflg_pkg;

  // loss mode codes
  localparam logic [2:0] LOSS_MSE   = 3'd0;
  localparam logic [2:0] LOSS_MGN   = 3'd1;
  localparam logic [2:0] LOSS_LOG   = 3'd2;
  localparam logic [2:0] LOSS_WLOG  = 3'd3;
  localparam logic [2:0] LOSS_EXP   = 3'd4;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_LOSS_MODE = 2'd0;
  localparam logic [1:0] REG_PAIR_MODE = 2'd1;
  localparam logic [1:0] REG_ERR_TOL   = 2'd2;

  localparam int unsigned DEF_CLASS_SLOTS = 64;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic signed [17:0] INV_LN2_Q16 = 18'sd94548;
  localparam logic [15:0]        LN2_Q16     = 16'd45426;

  // sigmoid over |x| in 0.5 steps, Q1.16
  localparam logic [16:0] SIG_TAB [25] = '{
    17'd32768, 17'd40793, 17'd47910, 17'd53580, 17'd57725, 17'd60565, 17'd62428,
    17'd63615, 17'd64357, 17'd64816, 17'd65097, 17'd65269, 17'd65374, 17'd65438,
    17'd65476, 17'd65500, 17'd65514, 17'd65523, 17'd65528, 17'd65531, 17'd65533,
    17'd65534, 17'd65535, 17'd65535, 17'd65536
  };

  // ln(1 + i/16), Q16
  localparam logic [15:0] LN_TAB [17] = '{
    16'd0, 16'd3973, 16'd7719, 16'd11262, 16'd14624, 16'd17821, 16'd20870,
    16'd23783, 16'd26573, 16'd29248, 16'd31818, 16'd34292, 16'd36675,
    16'd38975, 16'd41197, 16'd43345, 16'd45426
  };

  // 2^(i/16), Q16
  localparam logic [17:0] POW_TAB [17] = '{
    18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
    18'd84990, 18'd88753, 18'd92682, 18'd96785, 18'd101070, 18'd105545,
    18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
  };

  typedef struct packed {
    logic [2:0]  loss_mode;
    logic        pair_mode;
    logic [23:0] err_tol;
  } cfg_t;

  // word from the front to the back
  typedef struct packed {
    logic [31:0] loss;
    logic [31:0] grad;
    logic        ok;
    logic        has;
    logic [5:0]  cls;
  } q_ent_t;

  // per-class counter record
  typedef struct packed {
    logic [47:0] loss_sum;
    logic [31:0] correct;
    logic [31:0] frames;
  } cls_rec_t;

  // result word, last field (loss) in the lowest bits
  typedef struct packed {
    logic [47:0] class_loss;
    logic [31:0] class_correct;
    logic [31:0] class_frames;
    logic [47:0] run_loss;
    logic [31:0] run_correct;
    logic [31:0] total_frames;
    logic        correct;
    logic [31:0] gradient;
    logic [31:0] loss;
  } res_t;

endpackage

// ===== rtl/core/pflg_front.sv =====
// ----------------------------------------------------------------------------
// pflg_front: loss and gradient sequencer
// Takes one frame at a time through six steps: products, sigmoid and exp
// interpolation, log normalise, ln and exp shift, weighting, final select.
// ----------------------------------------------------------------------------
module pflg_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pflg_pkg::cfg_t        cfg_i,
  input  logic                  en_i,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic signed [23:0]    net_output_i,
  input  logic signed [23:0]    target_i,
  input  logic [5:0]            example_class_i,
  input  logic                  has_class_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output pflg_pkg::q_ent_t      ent_o
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_S1   = 3'd1;
  localparam logic [2:0] F_S2   = 3'd2;
  localparam logic [2:0] F_S3   = 3'd3;
  localparam logic [2:0] F_S4   = 3'd4;
  localparam logic [2:0] F_S5   = 3'd5;
  localparam logic [2:0] F_S6   = 3'd6;

  localparam logic signed [17:0] INV_LN2_Q16_S = pflg_pkg::INV_LN2_Q16;

  logic [2:0] step_q, step_d;

  // captured frame
  logic signed [23:0] f_q, t_q;
  logic [5:0]         cls_q;
  logic               has_q;

  // step 1 results
  logic               sg_q, fneg_q, ok_q, ssat_q, hpos_q;
  logic signed [24:0] q_q;
  logic [23:0]        at_q;
  logic [48:0]        sq_q;
  logic signed [42:0] pm_q;
  logic [16:0]        sbase_q;
  logic [28:0]        sprod_q;
  // step 2 results
  logic [16:0]        p_q, pc_q, v_q;
  logic signed [10:0] n_q;
  logic [17:0]        ebase_q;
  logic [24:0]        eprod_q;
  // step 3 results
  logic [15:0]        lbase_q;
  logic [23:0]        lprod_q;
  logic [4:0]         lsh_q;
  logic [17:0]        m_q;
  // step 4 results
  logic [19:0]        lg_q;
  logic [40:0]        e_q;
  // step 5 results
  logic [43:0]        wl_q;
  logic [40:0]        wg_q;

  // step 1 logic
  logic signed [24:0] f_x, t_x, q_x, z_x;
  logic signed [49:0] sq_x;
  logic signed [42:0] pm_x;
  logic [23:0]        a_x, at_x;
  logic [24:0]        aq_x;
  logic [8:0]         sidx_x;
  logic               ssat_x, sg_x, ok_x;
  logic [4:0]         si_x;
  logic [16:0]        sdif_x;

  always_comb begin
    f_x    = {f_q[23], f_q};
    t_x    = {t_q[23], t_q};
    q_x    = f_x - t_x;
    sg_x   = !t_q[23] && (t_q != 24'sd0);
    z_x    = sg_x ? -f_x : f_x;
    sq_x   = q_x * q_x;
    pm_x   = z_x * INV_LN2_Q16_S;
    a_x    = f_q[23] ? (~f_q + 24'd1) : f_q;
    at_x   = t_q[23] ? (~t_q + 24'd1) : t_q;
    aq_x   = q_x[24] ? 25'(-q_x) : 25'(q_x);
    sidx_x = a_x[23:15];
    ssat_x = sidx_x >= 9'd24;
    si_x   = ssat_x ? 5'd0 : sidx_x[4:0];
    sdif_x = pflg_pkg::SIG_TAB[si_x + 5'd1] - pflg_pkg::SIG_TAB[si_x];
    if (cfg_i.pair_mode) begin
      ok_x = (!f_q[23] && (f_q != 24'sd0) && sg_x) || (f_q[23] && t_q[23]);
    end else begin
      ok_x = aq_x < {1'b0, cfg_i.err_tol};
    end
  end

  // step 2 logic
  logic [16:0] s_x, p_x, pc_x;
  logic [29:0] sr_x;
  logic [15:0] efr_x;
  logic [4:0]  eix_x;
  logic [17:0] edif_x;

  always_comb begin
    sr_x   = 30'(sprod_q) + 30'd16384;
    s_x    = ssat_q ? 17'd65536 : sbase_q + 17'(sr_x >> 15);
    p_x    = fneg_q ? 17'd65536 - s_x : s_x;
    pc_x   = 17'd65536 - p_x;
    efr_x  = pm_q[31:16];
    eix_x  = {1'b0, efr_x[15:12]};
    edif_x = pflg_pkg::POW_TAB[eix_x + 5'd1] - pflg_pkg::POW_TAB[eix_x];
  end

  // step 3 logic: normalise (p or 1-p) + 1, look up ln of mantissa, round exp
  logic [4:0]  lz_x, lsh_x, lix_x;
  logic [16:0] vn_x;
  logic [15:0] mq_x, ldif_x;
  logic [25:0] er_x;

  always_comb begin
    lz_x = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (v_q[i]) begin
        lz_x = 5'(i);
      end
    end
    lsh_x  = 5'd16 - lz_x;
    vn_x   = v_q << lsh_x;
    mq_x   = vn_x[15:0];
    lix_x  = {1'b0, mq_x[15:12]};
    ldif_x = pflg_pkg::LN_TAB[lix_x + 5'd1] - pflg_pkg::LN_TAB[lix_x];
    er_x   = 26'(eprod_q) + 26'd2048;
  end

  // step 4 logic: ln result and exp shift
  logic [24:0] lr_x;
  logic [15:0] lnm_x;
  logic [20:0] lk_x;
  logic [10:0] nn_x;
  logic [4:0]  ns_x;
  logic [32:0] er2_x;
  logic [40:0] e_x;
  logic [19:0] lg_x;

  always_comb begin
    lr_x  = 25'(lprod_q) + 25'd2048;
    lnm_x = lbase_q + 16'(lr_x >> 12);
    lk_x  = 21'(lsh_q) * 21'(pflg_pkg::LN2_Q16);
    lg_x  = (lk_x < 21'(lnm_x)) ? 20'd0 : 20'(lk_x - 21'(lnm_x));
    nn_x  = 11'(-n_q);
    ns_x  = nn_x[4:0];
    er2_x = (33'(m_q) + (33'd1 << (ns_x - 5'd1))) >> ns_x;
    if (!n_q[10]) begin
      if (n_q >= 11'sd24) begin
        e_x = 41'h100_0000_0000;
      end else begin
        e_x = 41'(m_q) << n_q[4:0];
      end
    end else if (nn_x >= 11'd32) begin
      e_x = 41'd0;
    end else begin
      e_x = 41'(er2_x);
    end
  end

  // step 6 logic: pick loss and gradient by mode
  logic [49:0] sqr_x;
  logic [44:0] wlr_x;
  logic [41:0] wgr_x;
  logic [31:0] loss_x, grad_x, wgm_x;

  always_comb begin
    sqr_x = 50'(sq_q) + 50'd65536;
    wlr_x = 45'(wl_q) + 45'd32768;
    wgr_x = 42'(wg_q) + 42'd32768;
    wgm_x = 32'(wgr_x >> 16);
    unique case (cfg_i.loss_mode)
      pflg_pkg::LOSS_MSE: begin
        loss_x = 32'(sqr_x >> 17);
        grad_x = 32'(q_q);
      end
      pflg_pkg::LOSS_MGN: begin
        loss_x = hpos_q ? (sg_q ? 32'(-q_q) : 32'(q_q)) : 32'd0;
        grad_x = hpos_q ? (sg_q ? 32'hFFFF_0000 : 32'h0001_0000) : 32'd0;
      end
      pflg_pkg::LOSS_LOG: begin
        loss_x = 32'(lg_q);
        grad_x = sg_q ? 32'(-33'(pc_q)) : 32'(p_q);
      end
      pflg_pkg::LOSS_WLOG: begin
        loss_x = 32'(wlr_x >> 16);
        grad_x = sg_q ? (32'd0 - wgm_x) : wgm_x;
      end
      pflg_pkg::LOSS_EXP: begin
        loss_x = (e_q >= 41'h1_0000_0000) ? 32'hFFFF_FFFF : e_q[31:0];
        if (sg_q) begin
          grad_x = (e_q > 41'h8000_0000) ? 32'h8000_0000 : 32'(41'd0 - e_q);
        end else begin
          grad_x = (e_q > 41'h7FFF_FFFF) ? 32'h7FFF_FFFF : e_q[31:0];
        end
      end
      default: begin
        loss_x = 32'd0;
        grad_x = 32'd0;
      end
    endcase
  end

  // advance the step counter
  always_comb begin
    step_d = step_q;
    unique case (step_q)
      F_IDLE:  if (s_valid_i && s_ready_o) step_d = F_S1;
      F_S1:    step_d = F_S2;
      F_S2:    step_d = F_S3;
      F_S3:    step_d = F_S4;
      F_S4:    step_d = F_S5;
      F_S5:    step_d = F_S6;
      F_S6:    if (!q_full_i) step_d = F_IDLE;
      default: step_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= F_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // load each step's registers in its own step
  always_ff @(posedge clk_i) begin
    if (step_q == F_IDLE && s_valid_i && s_ready_o) begin
      f_q   <= net_output_i;
      t_q   <= target_i;
      cls_q <= example_class_i;
      has_q <= has_class_i;
    end
    if (step_q == F_S1) begin
      sg_q    <= sg_x;
      fneg_q  <= f_q[23];
      ok_q    <= ok_x;
      q_q     <= q_x;
      hpos_q  <= sg_x ? q_x[24] : (!q_x[24] && (q_x != 25'sd0));
      at_q    <= at_x;
      sq_q    <= sq_x[48:0];
      pm_q    <= pm_x;
      ssat_q  <= ssat_x;
      sbase_q <= pflg_pkg::SIG_TAB[si_x];
      sprod_q <= 29'(sdif_x[13:0]) * 29'(a_x[14:0]);
    end
    if (step_q == F_S2) begin
      p_q     <= p_x;
      pc_q    <= pc_x;
      v_q     <= (sg_q ? p_x : pc_x) + 17'd1;
      n_q     <= pm_q[42:32];
      ebase_q <= pflg_pkg::POW_TAB[eix_x];
      eprod_q <= 25'(edif_x[12:0]) * 25'(efr_x[11:0]);
    end
    if (step_q == F_S3) begin
      lbase_q <= pflg_pkg::LN_TAB[lix_x];
      lprod_q <= 24'(ldif_x[11:0]) * 24'(mq_x[11:0]);
      lsh_q   <= lsh_x;
      m_q     <= ebase_q + 18'(er_x >> 12);
    end
    if (step_q == F_S4) begin
      lg_q <= lg_x;
      e_q  <= e_x;
    end
    if (step_q == F_S5) begin
      wl_q <= 44'(lg_q) * 44'(at_q);
      wg_q <= 41'(sg_q ? pc_q : p_q) * 41'(at_q);
    end
  end

  assign s_ready_o  = en_i && (step_q == F_IDLE);
  assign push_o     = (step_q == F_S6) && !q_full_i;
  assign ent_o.loss = loss_x;
  assign ent_o.grad = grad_x;
  assign ent_o.ok   = ok_q;
  assign ent_o.has  = has_q;
  assign ent_o.cls  = cls_q;

endmodule

// ===== rtl/core/pflg_queue.sv =====
// ----------------------------------------------------------------------------
// pflg_queue: short word queue between front and back
// Two-entry first-in first-out buffer so either side can stall alone.
// ----------------------------------------------------------------------------
module pflg_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pflg_pkg::q_ent_t ent_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output pflg_pkg::q_ent_t head_o
);

  localparam int unsigned PtrW = $clog2(pflg_pkg::QUEUE_DEPTH);

  pflg_pkg::q_ent_t slot_q [pflg_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]  wp_q, rp_q;
  logic [PtrW:0]    cnt_q;

  // hold words in slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= ent_i;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  assign full_o  = cnt_q == (PtrW+1)'(pflg_pkg::QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = slot_q[rp_q];

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

endmodule

// ===== rtl/core/pflg_back.sv =====
// ----------------------------------------------------------------------------
// pflg_back: counter update and result register
// Clears the per-class memory after reset, then for each queued word reads
// the class record, updates global and class totals and loads the result.
// ----------------------------------------------------------------------------
module pflg_back #(
  parameter int unsigned CLASS_SLOTS = pflg_pkg::DEF_CLASS_SLOTS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  pflg_pkg::q_ent_t q_head_i,
  output logic             pop_o,
  output logic             clearing_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output pflg_pkg::res_t   res_o
);

  localparam int unsigned IdxW = (CLASS_SLOTS > 1) ? $clog2(CLASS_SLOTS) : 1;

  localparam logic [1:0] B_CLR  = 2'd0;
  localparam logic [1:0] B_IDLE = 2'd1;
  localparam logic [1:0] B_UPD  = 2'd2;

  logic [1:0] st_q, st_d;
  logic [IdxW-1:0] clr_q;

  pflg_pkg::cls_rec_t mem [CLASS_SLOTS];
  pflg_pkg::cls_rec_t rd_q, wr_rec;
  logic               wr_en;
  logic [IdxW-1:0]    wr_addr, rd_addr;

  pflg_pkg::q_ent_t ent_q;
  logic             hit_q;
  logic [31:0]      tot_frames_q, tot_correct_q;
  logic [47:0]      tot_loss_q;
  logic             m_vld_q;
  pflg_pkg::res_t   res_q;

  logic        load;
  logic [48:0] tsum, csum;
  logic [47:0] tot_loss_n;
  logic [31:0] tot_frames_n, tot_correct_n;
  pflg_pkg::cls_rec_t upd_rec;

  assign pop_o   = (st_q == B_IDLE) && q_valid_i && (!m_vld_q || m_ready_i);
  assign load    = st_q == B_UPD;
  assign rd_addr = IdxW'(q_head_i.cls);

  // update totals; sums saturate, counts wrap
  always_comb begin
    tot_frames_n  = tot_frames_q + 32'd1;
    tot_correct_n = tot_correct_q + 32'(ent_q.ok);
    tsum          = {1'b0, tot_loss_q} + 49'(ent_q.loss);
    tot_loss_n    = tsum[48] ? 48'hFFFF_FFFF_FFFF : tsum[47:0];
    csum          = {1'b0, rd_q.loss_sum} + 49'(ent_q.loss);
    upd_rec.frames   = rd_q.frames + 32'd1;
    upd_rec.correct  = rd_q.correct + 32'(ent_q.ok);
    upd_rec.loss_sum = csum[48] ? 48'hFFFF_FFFF_FFFF : csum[47:0];
  end

  // drive the single write port: zero sweep or record update
  always_comb begin
    if (st_q == B_CLR) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_rec  = '0;
    end else begin
      wr_en   = load && hit_q;
      wr_addr = IdxW'(ent_q.cls);
      wr_rec  = upd_rec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    if (pop_o) begin
      rd_q <= mem[rd_addr];
    end
  end

  // sequence clear, read and update
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      B_CLR:   if (clr_q == IdxW'(CLASS_SLOTS - 1)) st_d = B_IDLE;
      B_IDLE:  if (pop_o) st_d = B_UPD;
      B_UPD:   st_d = B_IDLE;
      default: st_d = B_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= B_CLR;
      clr_q         <= '0;
      tot_frames_q  <= '0;
      tot_correct_q <= '0;
      tot_loss_q    <= '0;
      m_vld_q       <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == B_CLR) clr_q <= clr_q + 1'b1;
      if (load) begin
        tot_frames_q  <= tot_frames_n;
        tot_correct_q <= tot_correct_n;
        tot_loss_q    <= tot_loss_n;
        m_vld_q       <= 1'b1;
      end else if (m_ready_i) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // hold the popped word and the result register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= q_head_i;
      hit_q <= q_head_i.has && (32'(q_head_i.cls) < 32'(CLASS_SLOTS));
    end
    if (load) begin
      res_q.loss          <= ent_q.loss;
      res_q.gradient      <= ent_q.grad;
      res_q.correct       <= ent_q.ok;
      res_q.total_frames  <= tot_frames_n;
      res_q.run_correct   <= tot_correct_n;
      res_q.run_loss      <= tot_loss_n;
      res_q.class_frames  <= hit_q ? upd_rec.frames : 32'd0;
      res_q.class_correct <= hit_q ? upd_rec.correct : 32'd0;
      res_q.class_loss    <= hit_q ? upd_rec.loss_sum : 48'd0;
    end
  end

  assign clearing_o = st_q == B_CLR;
  assign m_valid_o  = m_vld_q;
  assign res_o      = res_q;

  a_upd_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_UPD) |=> m_vld_q) else $error("update did not load result");

  a_frames_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_UPD) |=> (tot_frames_q == $past(tot_frames_q) + 32'd1))
    else $error("frame count did not advance by one");

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_CLR) |-> !pop_o) else $error("word taken during clear");

endmodule

// ===== rtl/core/per_frame_loss_and_gradient_core.sv =====
// ----------------------------------------------------------------------------
// per_frame_loss_and_gradient_core: frame loss, gradient and accuracy totals
// Channel      Dir  Handshake              Payload
// s_axis       in   tvalid/tready          tdata net_output,target,class; tuser
// m_axis       out  tvalid/tready          tdata loss .. class_loss
// apb          in   psel/penable/pwrite    loss_mode, pair_mode, error_tolerance
//
// The front sequencer works on one frame at a time and takes no new frame
// until the last one is pushed to the queue; the back reads and then writes
// the class memory for each word. After reset the class memory is zeroed
// with s_axis_tready low. A stalled m_axis fills the two-word queue, after
// which the front holds its last frame.
// ----------------------------------------------------------------------------
module per_frame_loss_and_gradient_core #(
  parameter int unsigned CLASS_SLOTS = pflg_pkg::DEF_CLASS_SLOTS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,  // net_output[23:0], target[47:24], example_class[53:48]
  input  logic [0:0]   s_axis_tuser,  // has_class[0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [295:0] m_axis_tdata,  // loss, gradient, correct, frame count,
                                      // correct count, loss sum, class_frames,
                                      // class_correct, class_loss
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  pflg_pkg::cfg_t   cfg_q;
  pflg_pkg::q_ent_t ent, head;
  pflg_pkg::res_t   res;
  logic push, full, pop, qvalid, clearing;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        pflg_pkg::REG_LOSS_MODE: cfg_q.loss_mode <= pwdata[2:0];
        pflg_pkg::REG_PAIR_MODE: cfg_q.pair_mode <= pwdata[0];
        pflg_pkg::REG_ERR_TOL:   cfg_q.err_tol   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[3:2])
      pflg_pkg::REG_LOSS_MODE: prdata = 32'(cfg_q.loss_mode);
      pflg_pkg::REG_PAIR_MODE: prdata = 32'(cfg_q.pair_mode);
      pflg_pkg::REG_ERR_TOL:   prdata = 32'(cfg_q.err_tol);
      default:                 prdata = 32'd0;
    endcase
  end

  assign pready = 1'b1;

  pflg_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i           (cfg_q),
    .en_i            (!clearing),
    .s_valid_i       (s_axis_tvalid),
    .s_ready_o       (s_axis_tready),
    .net_output_i    (s_axis_tdata[23:0]),
    .target_i        (s_axis_tdata[47:24]),
    .example_class_i (s_axis_tdata[53:48]),
    .has_class_i     (s_axis_tuser[0]),
    .q_full_i        (full),
    .push_o          (push),
    .ent_o           (ent)
  );

  pflg_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .ent_i   (ent),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (qvalid),
    .head_o  (head)
  );

  pflg_back #(
    .CLASS_SLOTS (CLASS_SLOTS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i  (qvalid),
    .q_head_i   (head),
    .pop_o      (pop),
    .clearing_o (clearing),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {7'd0, res};

endmodule

// ===== verif/per_frame_loss_and_gradient_core_tb.sv =====
// ----------------------------------------------------------------------------
// Frame loss core testbench
// Streams frames through every loss mode, both correctness rules and a range
// of error bands, predicts loss, gradient and the running totals in a local
// model of the core, and checks every result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_frame_loss_and_gradient_core_tb;

  localparam int unsigned SLOTS = pflg_pkg::DEF_CLASS_SLOTS;
  localparam longint unsigned LIMIT = 400000;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata;   // net_output, target, example_class, pad
  logic [0:0]   s_axis_tuser;   // has_class
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [295:0] m_axis_tdata;   // loss .. class_loss, first field lowest
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  longint unsigned cycles;
  int              err_count;
  int              frames_sent;
  bit              quiet;
  int              mode_hits [8];

  per_frame_loss_and_gradient_core u_top (.*);

  task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_count++;
    $display("t=%0t %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  // Running totals and per-class counters as the core should hold them
  class loss_scoreboard;
    logic [2:0]  mode;
    logic        pair;
    logic [23:0] tol;
    logic [31:0] n_all, ok_all;
    logic [47:0] l_all;
    logic [31:0] n_cls  [SLOTS];
    logic [31:0] ok_cls [SLOTS];
    logic [47:0] l_cls  [SLOTS];
    pflg_pkg::res_t pending [$];
    int          checked;

    function new();
      mode = pflg_pkg::LOSS_MSE; pair = 0; tol = 0;
      n_all = 0; ok_all = 0; l_all = 0; checked = 0;
      foreach (n_cls[i]) begin
        n_cls[i] = 0; ok_cls[i] = 0; l_cls[i] = 0;
      end
    endfunction

    function longint sigmoid(longint x);
      longint a, idx, fr, s;
      a = x < 0 ? -x : x;
      idx = a >>> 15;
      fr = a & 'h7FFF;
      if (idx >= 24) s = 65536;
      else s = longint'(pflg_pkg::SIG_TAB[idx]) +
          (((longint'(pflg_pkg::SIG_TAB[idx+1]) - longint'(pflg_pkg::SIG_TAB[idx])) * fr
            + 16384) >>> 15);
      return x < 0 ? 65536 - s : s;
    endfunction

    function longint neg_ln(longint p);
      longint v, mq, idx, fr, lnm, r;
      int e;
      v = p + 1;
      e = 16;
      while (e > 0 && (v >>> e) == 0) e--;
      if (e < 16) mq = (v - (longint'(1) <<< e)) <<< (16 - e);
      else mq = v - 65536;
      idx = (mq >>> 12) & 15;
      fr = mq & 'hFFF;
      lnm = longint'(pflg_pkg::LN_TAB[idx]) +
          (((longint'(pflg_pkg::LN_TAB[idx+1]) - longint'(pflg_pkg::LN_TAB[idx])) * fr
            + 2048) >>> 12);
      r = longint'(16 - e) * 45426 - lnm;
      return r < 0 ? 0 : r;
    endfunction

    function longint expo(longint z);
      longint unsigned pb;
      longint n, fr, idx, f2, m, e, sh;
      pb = z * 94548 + (longint'(256) <<< 32);
      n = longint'(pb >> 32) - 256;
      fr = longint'((pb >> 16) & 'hFFFF);
      idx = fr >>> 12;
      f2 = fr & 'hFFF;
      m = longint'(pflg_pkg::POW_TAB[idx]) +
          (((longint'(pflg_pkg::POW_TAB[idx+1]) - longint'(pflg_pkg::POW_TAB[idx])) * f2
            + 2048) >>> 12);
      if (n >= 0) e = n >= 24 ? (longint'(1) <<< 40) : (m <<< n);
      else begin
        sh = -n;
        e = sh >= 40 ? 0 : ((m + (longint'(1) <<< (sh - 1))) >>> sh);
      end
      return e > (longint'(1) <<< 40) ? (longint'(1) <<< 40) : e;
    endfunction

    function longint scale_mag(longint v, longint w);
      longint r;
      r = ((v < 0 ? -v : v) * w + 32768) >>> 16;
      return v < 0 ? -r : r;
    endfunction

    function logic [47:0] sat_add(logic [47:0] a, longint b);
      logic [48:0] s;
      s = {1'b0, a} + 49'(b);
      return s[48] ? MAX48 : s[47:0];
    endfunction

    // Note one accepted frame and queue its expected result word
    function void note_frame(logic signed [23:0] fo, logic signed [23:0] tg,
                             logic [5:0] cls, logic has);
      longint f, t, sg, q, ls, gr, p;
      logic ok;
      pflg_pkg::res_t r;
      f = fo; t = tg;
      sg = t > 0 ? 1 : -1;
      q = f - t;
      ls = 0; gr = 0;
      case (mode)
        pflg_pkg::LOSS_MSE: begin
          ls = (q * q + 65536) >>> 17; gr = q;
        end
        pflg_pkg::LOSS_MGN: begin
          if (sg * (t - f) > 0) begin
            ls = sg * (t - f); gr = -sg * 65536;
          end
        end
        pflg_pkg::LOSS_LOG, pflg_pkg::LOSS_WLOG: begin
          p = sigmoid(f);
          if (sg > 0) begin
            ls = neg_ln(p); gr = -(65536 - p);
          end else begin
            ls = neg_ln(65536 - p); gr = p;
          end
          if (mode == pflg_pkg::LOSS_WLOG) begin
            ls = scale_mag(ls, t < 0 ? -t : t);
            gr = scale_mag(gr, t < 0 ? -t : t);
          end
        end
        pflg_pkg::LOSS_EXP: begin
          ls = expo(-sg * f); gr = -sg * ls;
        end
        default: ;
      endcase
      if (ls > 64'sh0_FFFF_FFFF) ls = 64'sh0_FFFF_FFFF;
      if (gr > 64'sh0_7FFF_FFFF) gr = 64'sh0_7FFF_FFFF;
      if (gr < -64'sh0_8000_0000) gr = -64'sh0_8000_0000;
      if (pair) ok = (f > 0 && t > 0) || (f < 0 && t < 0);
      else ok = (q < 0 ? -q : q) < longint'(tol);
      n_all++;
      if (ok) ok_all++;
      l_all = sat_add(l_all, ls);
      r = '0;
      r.loss = ls[31:0];
      r.gradient = gr[31:0];
      r.correct = ok;
      r.total_frames = n_all;
      r.run_correct = ok_all;
      r.run_loss = l_all;
      if (has && (int'(cls) < SLOTS)) begin
        n_cls[cls]++;
        if (ok) ok_cls[cls]++;
        l_cls[cls] = sat_add(l_cls[cls], ls);
        r.class_frames = n_cls[cls];
        r.class_correct = ok_cls[cls];
        r.class_loss = l_cls[cls];
      end
      pending.insert(pending.size(), r);
    endfunction

    // Compare one result word with the oldest expectation
    task check_word(pflg_pkg::res_t got);
      pflg_pkg::res_t w;
      if (pending.size() == 0) begin
        report_mismatch("result word with nothing expected", 64'd0, 64'd0);
        return;
      end
      w = pending.pop_front();
      checked++;
      if (got.loss !== w.loss) report_mismatch("loss", 64'(got.loss), 64'(w.loss));
      if (got.gradient !== w.gradient)
        report_mismatch("gradient", 64'(got.gradient), 64'(w.gradient));
      if (got.correct !== w.correct)
        report_mismatch("correct", 64'(got.correct), 64'(w.correct));
      if (got.total_frames !== w.total_frames)
        report_mismatch("total_frames", 64'(got.total_frames), 64'(w.total_frames));
      if (got.run_correct !== w.run_correct)
        report_mismatch("run_correct", 64'(got.run_correct), 64'(w.run_correct));
      if (got.run_loss !== w.run_loss)
        report_mismatch("run_loss", 64'(got.run_loss), 64'(w.run_loss));
      if (got.class_frames !== w.class_frames)
        report_mismatch("class_frames", 64'(got.class_frames), 64'(w.class_frames));
      if (got.class_correct !== w.class_correct)
        report_mismatch("class_correct", 64'(got.class_correct), 64'(w.class_correct));
      if (got.class_loss !== w.class_loss)
        report_mismatch("class_loss", 64'(got.class_loss), 64'(w.class_loss));
    endtask
  endclass

  loss_scoreboard sb;

  // Clock and the cycle limit
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stalls, none once quiet
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata[288:0]);
  end

  initial begin
    int n;
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 0;
        n = $urandom_range(1, 14);
        repeat (n) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // Register write: setup, access, then idle
  task reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
    case (idx)
      pflg_pkg::REG_LOSS_MODE: sb.mode = val[2:0];
      pflg_pkg::REG_PAIR_MODE: sb.pair = val[0];
      default:                 sb.tol  = val[23:0];
    endcase
  endtask

  task set_config(logic [2:0] mode, logic pair, logic [23:0] tol);
    reg_write(pflg_pkg::REG_LOSS_MODE, 32'(mode));
    reg_write(pflg_pkg::REG_PAIR_MODE, 32'(pair));
    reg_write(pflg_pkg::REG_ERR_TOL, 32'(tol));
  endtask

  // Send one frame, with a random gap before it unless quiet
  task send_frame(logic [23:0] fo, logic [23:0] tg, logic [5:0] cls, logic has);
    int g;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 0;
      g = $urandom_range(1, 14);
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {2'b00, cls, tg, fo};
    s_axis_tuser <= has;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_frame(fo, tg, cls, has);
    mode_hits[sb.mode]++;
    frames_sent++;
  endtask

  // Wait for all results, then let the core settle
  task drain;
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function logic [23:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(0, 2097152)) - 1048576);
      3: return 24'($signed($urandom_range(0, 131072)) - 65536);
      default: return 24'($urandom);
    endcase
  endfunction

  task random_frames(int count);
    logic [23:0] fo, tg;
    repeat (count) begin
      fo = rand_val();
      tg = rand_val();
      if (tg == 0) tg = 24'd1;
      send_frame(fo, tg, 6'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    logic [23:0] edge_vals [6];
    sb = new();
    cycles = 0; err_count = 0; frames_sent = 0; quiet = 0;
    rst_ni = 0;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: field extremes through every mode, zero net output included
    edge_vals = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h010000, 24'hFF0000, 24'h000001};
    for (int m = 0; m < 6; m++) begin
      set_config(m == 5 ? 3'd7 : 3'(m), 1'(m & 1), m == 0 ? 24'hFFFFFF : 24'h010000);
      for (int k = 0; k < 4; k++)
        send_frame(edge_vals[(k + m) % 6], edge_vals[(k * 5 + 1) % 6],
                   k[0] ? 6'd63 : 6'd0, 1'(k != 2));
      drain();
    end

    // Random phases over all modes and settings, extremes of the band too
    for (int ph = 0; ph < 12; ph++) begin
      set_config(3'($urandom_range(0, 5)), 1'($urandom),
                 ph == 0 ? 24'hFFFFFF : (ph == 1 ? 24'h0 : 24'($urandom)));
      if (ph == 11) quiet = 1;
      random_frames(77);
      drain();
    end

    $display("%0d frames sent, %0d results checked; per mode: %0d %0d %0d %0d %0d other %0d",
             frames_sent, sb.checked, mode_hits[0], mode_hits[1], mode_hits[2],
             mode_hits[3], mode_hits[4], mode_hits[5] + mode_hits[6] + mode_hits[7]);
    if (err_count == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pflg_pkg.sv
rtl/core/pflg_front.sv
rtl/core/pflg_queue.sv
rtl/core/pflg_back.sv
rtl/core/per_frame_loss_and_gradient_core.sv
verif/per_frame_loss_and_gradient_core_tb.sv
